// ===== src/rci_pkg.sv =====
package rci_pkg;

	// Multiplier: abs, limb products, row sums, final sum, sign
	localparam int MUL_LAT = 5;

	// Square root: radicand of 2*SQRT_N bits, one root bit per stage
	localparam int SQRT_N = 63;

	// Divider: signed numerator, unsigned denominator, quotient bits kept
	localparam int DIV_NUM_W = 97;
	localparam int DIV_DEN_W = 64;
	localparam int DIV_QB    = 33;
	localparam int DIV_Q_W   = DIV_QB + 2;
	localparam int DIV_LAT   = DIV_QB + 3;

	// Register indexes on the write port
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS   = 2'd2;

	// Root selection flags taken from the quadratic terms
	typedef struct packed {
		logic azero;
		logic hneg;
		logic kneg;
		logic kpos;
	} rci_flags_t;

endpackage

// ===== src/rci_dly.sv =====
module rci_dly import rci_pkg::*; #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_s [D];

	// plain shift line, held on stall
	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= d;
			for (int i = 1; i < D; i++) begin
				pipe_s[i] <= pipe_s[i-1];
			end
		end
	end

	assign q = pipe_s[D-1];

endmodule

// ===== src/rci_mul.sv =====
module rci_mul import rci_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int LW = 32;
	localparam int NA = (AW + LW - 1) / LW;
	localparam int NB = (BW + LW - 1) / LW;
	localparam int RW = NB * LW + LW;
	localparam int MW = (NA + NB) * LW;
	localparam int PW = AW + BW;

	logic [AW-1:0]    ua, abs_a;
	logic [BW-1:0]    ub, abs_b;
	logic             neg_s1, neg_s2, neg_s3, neg_s4;
	logic [NA*LW-1:0] ma_s1;
	logic [NB*LW-1:0] mb_s1;
	logic [2*LW-1:0]  pp_s2 [NA][NB];
	logic [RW-1:0]    row_c [NA];
	logic [RW-1:0]    row_s3 [NA];
	logic [MW-1:0]    mag_c, mag_s4, negm;

	// magnitudes
	always_comb begin
		ua    = a;
		ub    = b;
		abs_a = ua[AW-1] ? (~ua + AW'(1)) : ua;
		abs_b = ub[BW-1] ? (~ub + BW'(1)) : ub;
	end

	// row sums of 32x32 limb products
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s2[i][j]) << (j * LW));
			end
		end
	end

	always_comb begin
		mag_c = '0;
		for (int i = 0; i < NA; i++) begin
			mag_c = mag_c + (MW'(row_s3[i]) << (i * LW));
		end
	end

	assign negm = ~mag_s4 + MW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= ua[AW-1] ^ ub[BW-1];
			ma_s1  <= (NA*LW)'(abs_a);
			mb_s1  <= (NB*LW)'(abs_b);
			neg_s2 <= neg_s1;
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= ma_s1[i*LW +: LW] * mb_s1[j*LW +: LW];
				end
			end
			neg_s3 <= neg_s2;
			row_s3 <= row_c;
			neg_s4 <= neg_s3;
			mag_s4 <= mag_c;
			p      <= neg_s4 ? negm[PW-1:0] : mag_s4[PW-1:0];
		end
	end

endmodule

// ===== src/rci_sqrt.sv =====
module rci_sqrt import rci_pkg::*; #(
	parameter int N = 63
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*N-1:0] rad,
	output logic [N-1:0]   root
);

	localparam int RW = N + 3;

	logic [RW-1:0]  rem_sk  [N];
	logic [N-1:0]   root_sk [N];
	logic [2*N-1:0] rad_sk  [N];

	// one root bit per stage, restoring form
	for (genvar k = 0; k < N; k++) begin : g_stg
		logic [RW-1:0]  rem_in, cur, trial;
		logic [N-1:0]   root_in;
		logic [2*N-1:0] rad_in;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_sk[k-1];
			assign root_in = root_sk[k-1];
			assign rad_in  = rad_sk[k-1];
		end

		always_comb begin
			cur   = {rem_in[RW-3:0], rad_in[2*N-1 -: 2]};
			trial = RW'({root_in, 2'b01});
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k]  <= ge ? (cur - trial) : cur;
				root_sk[k] <= {root_in[N-2:0], ge};
				rad_sk[k]  <= rad_in << 2;
			end
		end
	end

	assign root = root_sk[N-1];

endmodule

// ===== src/rci_div.sv =====
module rci_div import rci_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0]        den,
	output logic signed [DIV_Q_W-1:0]   quo
);

	localparam int MAGW = DIV_NUM_W - 1;
	localparam int RW   = DIV_DEN_W;

	logic [DIV_NUM_W-1:0] un, abs_n;
	logic                 neg_s0, neg_s1;
	logic [MAGW-1:0]      mag_s0;
	logic [RW-1:0]        den_s0, den_s1;
	logic                 ovf_s1;
	logic [RW-1:0]        rem_s1;
	logic [DIV_QB-1:0]    low_s1;

	logic [RW-1:0]     rem_sk [DIV_QB];
	logic [DIV_QB-1:0] low_sk [DIV_QB];
	logic [DIV_QB-1:0] quo_sk [DIV_QB];
	logic [RW-1:0]     den_sk [DIV_QB];
	logic              neg_sk [DIV_QB];
	logic              ovf_sk [DIV_QB];

	logic [DIV_QB:0]    qm;
	logic [DIV_Q_W-1:0] qx;

	always_comb begin
		un    = num;
		abs_n = un[DIV_NUM_W-1] ? (~un + DIV_NUM_W'(1)) : un;
	end

	// magnitude, then overflow check and split of the numerator
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s0 <= un[DIV_NUM_W-1];
			mag_s0 <= abs_n[MAGW-1:0];
			den_s0 <= den;
			neg_s1 <= neg_s0;
			den_s1 <= den_s0;
			ovf_s1 <= (RW'(mag_s0[MAGW-1:DIV_QB]) >= den_s0);
			rem_s1 <= RW'(mag_s0[MAGW-1:DIV_QB]);
			low_s1 <= mag_s0[DIV_QB-1:0];
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < DIV_QB; k++) begin : g_stg
		logic [RW-1:0]     rem_in, den_in;
		logic [DIV_QB-1:0] low_in, quo_in;
		logic              neg_in, ovf_in, ge;
		logic [RW:0]       cur, dif;

		if (k == 0) begin : g_first
			assign rem_in = rem_s1;
			assign low_in = low_s1;
			assign quo_in = '0;
			assign den_in = den_s1;
			assign neg_in = neg_s1;
			assign ovf_in = ovf_s1;
		end else begin : g_next
			assign rem_in = rem_sk[k-1];
			assign low_in = low_sk[k-1];
			assign quo_in = quo_sk[k-1];
			assign den_in = den_sk[k-1];
			assign neg_in = neg_sk[k-1];
			assign ovf_in = ovf_sk[k-1];
		end

		always_comb begin
			cur = {rem_in, low_in[DIV_QB-1]};
			dif = cur - {1'b0, den_in};
			ge  = (cur >= {1'b0, den_in});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k] <= ge ? dif[RW-1:0] : cur[RW-1:0];
				low_sk[k] <= low_in << 1;
				quo_sk[k] <= {quo_in[DIV_QB-2:0], ge};
				den_sk[k] <= den_in;
				neg_sk[k] <= neg_in;
				ovf_sk[k] <= ovf_in;
			end
		end
	end

	// clamp large quotients, then apply sign
	always_comb begin
		qm = ovf_sk[DIV_QB-1] ? ((DIV_QB+1)'(1) << DIV_QB) : {1'b0, quo_sk[DIV_QB-1]};
		qx = {1'b0, qm};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_sk[DIV_QB-1] ? (~qx + DIV_Q_W'(1)) : qx;
		end
	end

endmodule

// ===== src/ray_circle_intersect.sv =====
// Channel   Direction  Signals                              Transfer when
// in        sink       ray_x ray_y dir_x dir_y              in_valid & in_ready
// out       source     hit hit_x hit_y                      out_valid & out_ready
// write     sink       wr_index wr_data                     wr_en
//
// One ray per cycle while results are taken; each ray passes 119 register stages on its
// way to the output register. Most of them lie in the 63-stage square root and the
// 36-stage dividers (33 quotient bits), plus three 5-stage multipliers.
// Reset clears the valid bits and loads the circle registers (radius 1.0).
// A held result stalls every stage together; nothing is dropped or repeated.
module ray_circle_intersect import rci_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] ray_x,
	input  logic signed [31:0] ray_y,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);

	// stage positions along the pipe
	localparam int T_P1   = 1 + MUL_LAT;
	localparam int T_SUM  = T_P1 + 1;
	localparam int T_P2   = T_SUM + MUL_LAT;
	localparam int T_Q    = T_P2 + 1;
	localparam int T_ROOT = T_Q + SQRT_N;
	localparam int T_N    = T_ROOT + 1;
	localparam int T_P3   = T_N + MUL_LAT;
	localparam int T_DIV  = T_P3 + DIV_LAT;
	localparam int T_OUT  = T_DIV + 1;

	logic signed [31:0] cx_q, cy_q;
	logic [30:0]        r_q;
	logic               en;
	logic [T_OUT:1]     vld_q;

	// circle registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			r_q  <= 31'(1) << FRAC_BITS;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_X: cx_q <= wr_data;
				REG_CENTER_Y: cy_q <= wr_data;
				REG_RADIUS:   r_q  <= wr_data[30:0];
				default:      ;
			endcase
		end
	end

	// global advance: move unless the output holds an untaken result
	assign en        = out_ready | ~vld_q[T_OUT];
	assign in_ready  = en;
	assign out_valid = vld_q[T_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[T_OUT-1:1], in_valid};
		end
	end

	// stage 1: capture ray, offset from centre
	logic signed [31:0] ox_s1, oy_s1, dx_s1, dy_s1, r_s1;
	logic signed [32:0] fx_s1, fy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s1 <= ray_x;
			oy_s1 <= ray_y;
			dx_s1 <= dir_x;
			dy_s1 <= dir_y;
			fx_s1 <= {ray_x[31], ray_x} - {cx_q[31], cx_q};
			fy_s1 <= {ray_y[31], ray_y} - {cy_q[31], cy_q};
			r_s1  <= {1'b0, r_q};
		end
	end

	// first products
	logic signed [63:0] dxdx, dydy, rr;
	logic signed [64:0] dxfx, dyfy, dxfy, dyfx;
	logic signed [65:0] fxfx, fyfy;

	rci_mul #(.AW(32), .BW(32)) u_dxdx (.clk, .en, .a(dx_s1), .b(dx_s1), .p(dxdx));
	rci_mul #(.AW(32), .BW(32)) u_dydy (.clk, .en, .a(dy_s1), .b(dy_s1), .p(dydy));
	rci_mul #(.AW(32), .BW(32)) u_rr   (.clk, .en, .a(r_s1),  .b(r_s1),  .p(rr));
	rci_mul #(.AW(32), .BW(33)) u_dxfx (.clk, .en, .a(dx_s1), .b(fx_s1), .p(dxfx));
	rci_mul #(.AW(32), .BW(33)) u_dyfy (.clk, .en, .a(dy_s1), .b(fy_s1), .p(dyfy));
	rci_mul #(.AW(32), .BW(33)) u_dxfy (.clk, .en, .a(dx_s1), .b(fy_s1), .p(dxfy));
	rci_mul #(.AW(32), .BW(33)) u_dyfx (.clk, .en, .a(dy_s1), .b(fx_s1), .p(dyfx));
	rci_mul #(.AW(33), .BW(33)) u_fxfx (.clk, .en, .a(fx_s1), .b(fx_s1), .p(fxfx));
	rci_mul #(.AW(33), .BW(33)) u_fyfy (.clk, .en, .a(fy_s1), .b(fy_s1), .p(fyfy));

	// stage 7: quadratic terms A, H, K and cross product C
	logic [63:0]        a_s7;
	logic [61:0]        rr_s7;
	logic signed [65:0] h_s7, c_s7;
	logic signed [66:0] k_s7;
	rci_flags_t         flg_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s7  <= dxdx[63:0] + dydy[63:0];
			rr_s7 <= rr[61:0];
			h_s7  <= {dxfx[64], dxfx} + {dyfy[64], dyfy};
			c_s7  <= {dxfy[64], dxfy} - {dyfx[64], dyfx};
			k_s7  <= {fxfx[65], fxfx} + {fyfy[65], fyfy} - {5'b0, rr[61:0]};
		end
	end

	always_comb begin
		flg_s7.azero = ~|a_s7;
		flg_s7.hneg  = h_s7[65];
		flg_s7.kneg  = k_s7[66];
		flg_s7.kpos  = ~k_s7[66] & (|k_s7);
	end

	// discriminant as A*r^2 - C^2
	logic signed [127:0] arr;
	logic signed [131:0] cc;

	rci_mul #(.AW(65), .BW(63)) u_arr (
		.clk, .en, .a({1'b0, a_s7}), .b({1'b0, rr_s7}), .p(arr)
	);
	rci_mul #(.AW(66), .BW(66)) u_cc (.clk, .en, .a(c_s7), .b(c_s7), .p(cc));

	logic [129:0] q_c;
	logic         qneg_s13;
	logic [125:0] rad_s13;

	assign q_c = {2'b0, arr[127:0]} - {1'b0, cc[128:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			qneg_s13 <= q_c[129];
			rad_s13  <= q_c[125:0];
		end
	end

	logic [SQRT_N-1:0] root;

	rci_sqrt #(.N(SQRT_N)) u_sqrt (.clk, .en, .rad(rad_s13), .root(root));

	// side data carried to the root
	logic signed [65:0] h_d;
	rci_flags_t         flg_d;
	logic               qneg_d;

	rci_dly #(.W(66 + $bits(rci_flags_t)), .D(T_ROOT - T_SUM)) u_dly_h (
		.clk, .en, .d({h_s7, flg_s7}), .q({h_d, flg_d})
	);
	rci_dly #(.W(1), .D(T_ROOT - T_Q)) u_dly_qneg (
		.clk, .en, .d(qneg_s13), .q(qneg_d)
	);

	// root selection: near root when ahead of a point outside the circle
	logic signed [66:0] hx, sx, n_c;
	logic               near;
	logic signed [65:0] n_s77;
	logic               miss_s77;

	always_comb begin
		hx   = {h_d[65], h_d};
		sx   = {4'b0, root};
		near = flg_d.hneg & flg_d.kpos;
		n_c  = near ? (-hx - sx) : (-hx + sx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s77    <= n_c[65:0];
			miss_s77 <= flg_d.azero | qneg_d | ~(flg_d.hneg | flg_d.kneg);
		end
	end

	// offsets D*N / A
	logic signed [31:0]  dx_d, dy_d, ox_d, oy_d;
	logic [63:0]         a_d;
	logic signed [97:0]  dxn, dyn;
	logic signed [DIV_Q_W-1:0] qx, qy;
	logic                miss_d;

	rci_dly #(.W(64), .D(T_N - 1)) u_dly_d (
		.clk, .en, .d({dx_s1, dy_s1}), .q({dx_d, dy_d})
	);
	rci_dly #(.W(64), .D(T_DIV - 1)) u_dly_o (
		.clk, .en, .d({ox_s1, oy_s1}), .q({ox_d, oy_d})
	);
	rci_dly #(.W(64), .D(T_P3 - T_SUM)) u_dly_a (
		.clk, .en, .d(a_s7), .q(a_d)
	);
	rci_dly #(.W(1), .D(T_DIV - T_N)) u_dly_miss (
		.clk, .en, .d(miss_s77), .q(miss_d)
	);

	rci_mul #(.AW(32), .BW(66)) u_dxn (.clk, .en, .a(dx_d), .b(n_s77), .p(dxn));
	rci_mul #(.AW(32), .BW(66)) u_dyn (.clk, .en, .a(dy_d), .b(n_s77), .p(dyn));

	rci_div u_div_x (.clk, .en, .num(dxn[DIV_NUM_W-1:0]), .den(a_d), .quo(qx));
	rci_div u_div_y (.clk, .en, .num(dyn[DIV_NUM_W-1:0]), .den(a_d), .quo(qy));

	// point = origin + offset, saturated to 32 bits
	logic signed [DIV_Q_W:0] px, py;
	logic signed [31:0]      sat_x, sat_y;

	always_comb begin
		px = {{(DIV_Q_W-31){ox_d[31]}}, ox_d} + {qx[DIV_Q_W-1], qx};
		py = {{(DIV_Q_W-31){oy_d[31]}}, oy_d} + {qy[DIV_Q_W-1], qy};
		if (px[DIV_Q_W:31] == {(DIV_Q_W-30){px[DIV_Q_W]}}) begin
			sat_x = px[31:0];
		end else begin
			sat_x = px[DIV_Q_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		if (py[DIV_Q_W:31] == {(DIV_Q_W-30){py[DIV_Q_W]}}) begin
			sat_y = py[31:0];
		end else begin
			sat_y = py[DIV_Q_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			hit   <= ~miss_d;
			hit_x <= miss_d ? '0 : sat_x;
			hit_y <= miss_d ? '0 : sat_y;
		end
	end

endmodule
